FILE: hdl/tds_meter_with_alert_timers_top_assert.svh
// Assertion macros used by the top module, which checks itself.
`ifndef TDS_METER_WITH_ALERT_TIMERS_TOP_ASSERT_SVH
`define TDS_METER_WITH_ALERT_TIMERS_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define TDSM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tdsm check failed");

// Next-cycle implication.
`define TDSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tdsm check failed");

`endif

FILE: hdl/tdsm_pkg.sv
package tdsm_pkg;

  // Shared serial arithmetic widths.
  localparam int unsigned MUL_A_W = 28;
  localparam int unsigned MUL_B_W = 24;
  localparam int unsigned DIV_N_W = 48;
  localparam int unsigned DIV_D_W = 24;

  localparam int unsigned SAMPLE_COUNT_DEF = 10;

  // Conversion constants in fixed point.
  localparam logic [23:0] VOLT_SCALE  = 24'd2162688;  // 33 * 65536
  localparam logic [23:0] VOLT_DIV    = 24'd40950;
  localparam logic [23:0] EC_GAIN     = 24'd800;
  localparam logic [10:0] TEMP_OFFSET = 11'd400;
  localparam logic [9:0]  TEMP_MAX    = 10'd960;
  localparam logic [19:0] EC_MAX      = 20'hFFFFF;
  localparam logic [23:0] COEF_CUBE   = 24'd13342;
  localparam logic [23:0] COEF_SQUARE = 24'd25586;
  localparam logic [23:0] COEF_LINEAR = 24'd85739;
  localparam logic [23:0] TDS_DIV     = 24'd1310720;  // 20 * 65536
  localparam logic [16:0] TDS_MAX     = 17'd99999;
  localparam logic [16:0] ANOMALY_LIMIT = 17'd5000;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CAL     = 2'd0;
  localparam logic [1:0] CFG_ROUTINE = 2'd1;
  localparam logic [1:0] CFG_ANOMALY = 2'd2;

  typedef enum logic [1:0] {
    ALERT_NONE    = 2'd0,
    ALERT_ANOMALY = 2'd1,
    ALERT_ROUTINE = 2'd2
  } alert_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AVG,
    S_VMUL,
    S_VDIV,
    S_EMUL1,
    S_EMUL2,
    S_EDIV,
    S_E2,
    S_E3,
    S_P3,
    S_P2,
    S_P1,
    S_TDIV,
    S_FINISH
  } state_e;

endpackage

FILE: hdl/tdsm_mul.sv
module tdsm_mul #(
  parameter int unsigned A_W = 28,
  parameter int unsigned B_W = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic               done_o,
  output logic [A_W+B_W-1:0] p_o
);

  localparam int unsigned P_W   = A_W + B_W;
  localparam int unsigned CNT_W = $clog2(B_W);

  logic [P_W-1:0]   acc_q, acc_d, a_q, a_d;
  logic [B_W-1:0]   b_q, b_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;

  // Shift-add, one multiplier bit per cycle.
  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      a_d    = P_W'(a_i);
      b_d    = b_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_d = acc_q + a_q;
      end
      a_d   = a_q << 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(B_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

FILE: hdl/tdsm_div.sv
module tdsm_div #(
  parameter int unsigned N_W = 48,
  parameter int unsigned D_W = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] num_i,
  input  logic [D_W-1:0] den_i,
  output logic           done_o,
  output logic [N_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(N_W);

  logic [N_W-1:0]   q_q, q_d;
  logic [D_W-1:0]   den_q, den_d, rem_q, rem_d;
  logic [D_W:0]     rem_sh;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    q_d    = q_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q, q_q[N_W-1]};
    if (start_i) begin
      q_d    = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = D_W'(rem_sh - {1'b0, den_q});
        q_d   = {q_q[N_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[D_W-1:0];
        q_d   = {q_q[N_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(N_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

FILE: hdl/tds_meter_with_alert_timers_top.sv
// A sample that does not complete a block is absorbed with no output; a completing sample
// starts a conversion of four divisions (48 quotient bits each) and eight multiplications
// (24 multiplier bits each) on the shared serial units, whose result goes to the output register.
// No new sample is taken while a conversion runs, and the conversion waits at its end
// while an earlier result still sits in the output register.
// Reset (asynchronous, active low) clears sum, index, both alert timers and the output
// valid flag, and loads the configuration registers with their default values.
module tds_meter_with_alert_timers_top #(
  parameter int unsigned SAMPLE_COUNT = tdsm_pkg::SAMPLE_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [11:0]        adc_sample_i,
  input  logic signed [11:0] water_temp_i,
  input  logic [31:0]        now_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [16:0]        tds_tenths_o,
  output logic [11:0]        average_adc_o,
  output logic [2:0]         quality_class_o,
  output logic [1:0]         alert_kind_o,
  output logic               temp_clamped_o,
  output logic               tds_saturated_o
);

  import tdsm_pkg::*;

  `include "tds_meter_with_alert_timers_top_assert.svh"

  // The block length, matched against the index plus one; the index counter is four bits wide.
  localparam logic [3:0] IDX_LAST = 4'(SAMPLE_COUNT);

  state_e state_q, state_d;

  // Configuration registers.
  logic [15:0] cal_q, cal_d;
  logic [31:0] routine_iv_q, routine_iv_d, anomaly_iv_q, anomaly_iv_d;

  // Accumulation and alert timer state.
  logic [15:0] sum_q, sum_d, sum_next;
  logic [3:0]  idx_q, idx_d;
  logic [31:0] routine_last_q, routine_last_d, anomaly_last_q, anomaly_last_d;

  // Working registers of the conversion sequence.
  logic [11:0]        avg_q, avg_d;
  logic [9:0]         t16_q, t16_d;
  logic               clamp_q, clamp_d;
  logic [31:0]        now_q, now_d;
  logic [19:0]        ec_q, ec_d;
  logic [23:0]        e2_q, e2_d;
  logic signed [49:0] s_q, s_d;
  logic [16:0]        tds_q, tds_d;
  logic               sat_q, sat_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [16:0] out_tds_q, out_tds_d;
  logic [11:0] out_avg_q, out_avg_d;
  logic [2:0]  out_cls_q, out_cls_d;
  alert_e      out_alert_q, out_alert_d;
  logic        out_clamp_q, out_clamp_d;
  logic        out_sat_q, out_sat_d;

  // Shared serial units.
  logic                       mul_start, mul_done;
  logic [MUL_A_W-1:0]         mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic [MUL_A_W+MUL_B_W-1:0] mul_p;
  logic                       div_start, div_done;
  logic [DIV_N_W-1:0]         div_num, div_quot;
  logic [DIV_D_W-1:0]         div_den;

  logic [10:0] temp_den;
  logic [31:0] since_anomaly, since_routine;
  logic [2:0]  cls;

  // Terms used by the checks at the end.
  logic last_sample, out_anomaly;

  tdsm_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
    .clk_i, .rst_ni,
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  tdsm_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign in_ready_o    = (state_q == S_IDLE);
  assign sum_next      = sum_q + 16'(adc_sample_i);
  assign temp_den      = TEMP_OFFSET + 11'(t16_q);
  assign since_anomaly = now_q - anomaly_last_q;
  assign since_routine = now_q - routine_last_q;

  // Quality band from the TDS in tenths of ppm.
  always_comb begin
    if (tds_q <= 17'd500) begin
      cls = 3'd0;
    end else if (tds_q <= 17'd1000) begin
      cls = 3'd1;
    end else if (tds_q <= 17'd2000) begin
      cls = 3'd2;
    end else if (tds_q <= 17'd3000) begin
      cls = 3'd3;
    end else if (tds_q <= 17'd4000) begin
      cls = 3'd4;
    end else if (tds_q <= 17'd5000) begin
      cls = 3'd5;
    end else begin
      cls = 3'd6;
    end
  end

  // Configuration writes; an index past the list is ignored.
  always_comb begin
    cal_d        = cal_q;
    routine_iv_d = routine_iv_q;
    anomaly_iv_d = anomaly_iv_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CAL:     cal_d        = cfg_data_i[15:0];
        CFG_ROUTINE: routine_iv_d = cfg_data_i;
        CFG_ANOMALY: anomaly_iv_d = cfg_data_i;
        default:     ;
      endcase
    end
  end

  // Sequencer: each state from S_AVG to S_P1 waits for one serial operation, stores what it needs
  // of the result and launches the next one in the same cycle; S_TDIV ends with the last division.
  always_comb begin
    state_d        = state_q;
    sum_d          = sum_q;
    idx_d          = idx_q;
    routine_last_d = routine_last_q;
    anomaly_last_d = anomaly_last_q;
    avg_d          = avg_q;
    t16_d          = t16_q;
    clamp_d        = clamp_q;
    now_d          = now_q;
    ec_d           = ec_q;
    e2_d           = e2_q;
    s_d            = s_q;
    tds_d          = tds_q;
    sat_d          = sat_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    out_tds_d      = out_tds_q;
    out_avg_d      = out_avg_q;
    out_cls_d      = out_cls_q;
    out_alert_d    = out_alert_q;
    out_clamp_d    = out_clamp_q;
    out_sat_d      = out_sat_q;
    mul_start      = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    div_start      = 1'b0;
    div_num        = '0;
    div_den        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (idx_q + 4'd1 == IDX_LAST) begin
            // The completing sample starts the conversion with the block average.
            sum_d     = '0;
            idx_d     = '0;
            now_d     = now_ms_i;
            div_start = 1'b1;
            div_num   = DIV_N_W'(sum_next);
            div_den   = DIV_D_W'(SAMPLE_COUNT);
            if (water_temp_i < 0) begin
              t16_d   = '0;
              clamp_d = 1'b1;
            end else if (water_temp_i > $signed({2'b00, TEMP_MAX})) begin
              t16_d   = TEMP_MAX;
              clamp_d = 1'b1;
            end else begin
              t16_d   = water_temp_i[9:0];
              clamp_d = 1'b0;
            end
            state_d = S_AVG;
          end else begin
            sum_d = sum_next;
            idx_d = idx_q + 4'd1;
          end
        end
      end
      S_AVG: begin
        if (div_done) begin
          avg_d     = div_quot[11:0];
          mul_start = 1'b1;
          mul_a     = MUL_A_W'(div_quot[11:0]);
          mul_b     = MUL_B_W'(VOLT_SCALE);
          state_d   = S_VMUL;
        end
      end
      S_VMUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_num   = DIV_N_W'(mul_p);
          div_den   = DIV_D_W'(VOLT_DIV);
          state_d   = S_VDIV;
        end
      end
      S_VDIV: begin
        if (div_done) begin
          // Volts in Q2.16 times 800.
          mul_start = 1'b1;
          mul_a     = MUL_A_W'(div_quot[17:0]);
          mul_b     = MUL_B_W'(EC_GAIN);
          state_d   = S_EMUL1;
        end
      end
      S_EMUL1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mul_p[MUL_A_W-1:0];
          mul_b     = MUL_B_W'(cal_q);
          state_d   = S_EMUL2;
        end
      end
      S_EMUL2: begin
        if (mul_done) begin
          // Temperature coefficient times 800, times 4096 for the calibration scale.
          div_start = 1'b1;
          div_num   = DIV_N_W'(mul_p);
          div_den   = DIV_D_W'({temp_den, 12'd0});
          state_d   = S_EDIV;
        end
      end
      S_EDIV: begin
        if (div_done) begin
          if (div_quot > DIV_N_W'(EC_MAX)) begin
            ec_d = EC_MAX;
          end else begin
            ec_d = div_quot[19:0];
          end
          mul_start = 1'b1;
          mul_a     = MUL_A_W'(ec_d);
          mul_b     = MUL_B_W'(ec_d);
          state_d   = S_E2;
        end
      end
      S_E2: begin
        if (mul_done) begin
          e2_d      = mul_p[39:16];
          mul_start = 1'b1;
          mul_a     = MUL_A_W'(mul_p[39:16]);
          mul_b     = MUL_B_W'(ec_q);
          state_d   = S_E3;
        end
      end
      S_E3: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = MUL_A_W'(mul_p[43:16]);
          mul_b     = MUL_B_W'(COEF_CUBE);
          state_d   = S_P3;
        end
      end
      S_P3: begin
        if (mul_done) begin
          s_d       = $signed({2'b00, mul_p[47:0]});
          mul_start = 1'b1;
          mul_a     = MUL_A_W'(e2_q);
          mul_b     = MUL_B_W'(COEF_SQUARE);
          state_d   = S_P2;
        end
      end
      S_P2: begin
        if (mul_done) begin
          s_d       = s_q - $signed({2'b00, mul_p[47:0]});
          mul_start = 1'b1;
          mul_a     = MUL_A_W'(ec_q);
          mul_b     = MUL_B_W'(COEF_LINEAR);
          state_d   = S_P1;
        end
      end
      S_P1: begin
        if (mul_done) begin
          s_d       = s_q + $signed({2'b00, mul_p[47:0]});
          div_start = 1'b1;
          // A negative polynomial value counts as zero.
          div_num   = s_d[49] ? '0 : DIV_N_W'(s_d[47:0]);
          div_den   = DIV_D_W'(TDS_DIV);
          state_d   = S_TDIV;
        end
      end
      S_TDIV: begin
        if (div_done) begin
          if (div_quot > DIV_N_W'(TDS_MAX)) begin
            tds_d = TDS_MAX;
            sat_d = 1'b1;
          end else begin
            tds_d = div_quot[16:0];
            sat_d = 1'b0;
          end
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        // Once the output register is free, post the result; an alert restarts both timers.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_tds_d   = tds_q;
          out_avg_d   = avg_q;
          out_cls_d   = cls;
          out_clamp_d = clamp_q;
          out_sat_d   = sat_q;
          out_alert_d = ALERT_NONE;
          if (tds_q > ANOMALY_LIMIT) begin
            if (since_anomaly >= anomaly_iv_q) begin
              out_alert_d    = ALERT_ANOMALY;
              anomaly_last_d = now_q;
              routine_last_d = now_q;
            end
          end else begin
            if (since_routine >= routine_iv_q) begin
              out_alert_d    = ALERT_ROUTINE;
              anomaly_last_d = now_q;
              routine_last_d = now_q;
            end
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      cal_q          <= 16'd4096;
      routine_iv_q   <= 32'd1260000;
      anomaly_iv_q   <= 32'd600000;
      sum_q          <= '0;
      idx_q          <= '0;
      routine_last_q <= '0;
      anomaly_last_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      cal_q          <= cal_d;
      routine_iv_q   <= routine_iv_d;
      anomaly_iv_q   <= anomaly_iv_d;
      sum_q          <= sum_d;
      idx_q          <= idx_d;
      routine_last_q <= routine_last_d;
      anomaly_last_q <= anomaly_last_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    avg_q       <= avg_d;
    t16_q       <= t16_d;
    clamp_q     <= clamp_d;
    now_q       <= now_d;
    ec_q        <= ec_d;
    e2_q        <= e2_d;
    s_q         <= s_d;
    tds_q       <= tds_d;
    sat_q       <= sat_d;
    out_tds_q   <= out_tds_d;
    out_avg_q   <= out_avg_d;
    out_cls_q   <= out_cls_d;
    out_alert_q <= out_alert_d;
    out_clamp_q <= out_clamp_d;
    out_sat_q   <= out_sat_d;
  end

  assign out_valid_o     = out_valid_q;
  assign tds_tenths_o    = out_tds_q;
  assign average_adc_o   = out_avg_q;
  assign quality_class_o = out_cls_q;
  assign alert_kind_o    = out_alert_q;
  assign temp_clamped_o  = out_clamp_q;
  assign tds_saturated_o = out_sat_q;

  assign last_sample = in_valid_i && in_ready_o && (idx_q + 4'd1 == IDX_LAST);
  assign out_anomaly = out_valid_o && (alert_kind_o == ALERT_ANOMALY);

  // Only one serial unit is ever at work, so their completions never coincide.
  `TDSM_ASSERT_NOW(a_one_unit, mul_done, !div_done)
  // A completing sample always starts the averaging division.
  `TDSM_ASSERT_NEXT(a_block_start, last_sample, state_q == S_AVG)
  // An anomaly alert is only raised above the TDS limit.
  `TDSM_ASSERT_NOW(a_anomaly_limit, out_anomaly, tds_tenths_o > ANOMALY_LIMIT)
  // A saturated result carries the full-scale value.
  `TDSM_ASSERT_NOW(a_sat_value, out_valid_o && tds_saturated_o, tds_tenths_o == TDS_MAX)

endmodule

FILE: verif/tds_meter_with_alert_timers_top_tb.sv
`timescale 1ns / 1ps

module tds_meter_with_alert_timers_top_tb;
  import tdsm_pkg::*;

  // Index 3 lies past the register list, so the block must ignore writes to it.
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned BLOCK_LEN = SAMPLE_COUNT_DEF;
  // Cycles of quiet after the last result.
  // This covers a block that may still be working on a result.
  localparam int unsigned SETTLE_CYCLES = 450;
  // Longest stretch with no transaction on either side before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 6000;
  localparam int unsigned BLOCKS_PER_PHASE = 29;
  localparam int unsigned NUM_PHASES = 5;
  localparam int unsigned NUM_DIRECTED = 20;

  typedef struct packed {
    logic [16:0] tds_tenths;
    logic [11:0] average_adc;
    logic [2:0]  quality_class;
    alert_e      alert_kind;
    logic        temp_clamped;
    logic        tds_saturated;
  } reading_t;

  typedef struct {
    logic [11:0] adc;
    logic [11:0] temp;
    logic [31:0] now;
    bit          typed;
    reading_t    want;
  } sample_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = CFG_CAL;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [11:0]        adc_sample_i = '0;
  logic signed [11:0] water_temp_i = '0;
  logic [31:0]        now_ms_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [16:0]        tds_tenths_o;
  logic [11:0]        average_adc_o;
  logic [2:0]         quality_class_o;
  logic [1:0]         alert_kind_o;
  logic               temp_clamped_o;
  logic               tds_saturated_o;

  tds_meter_with_alert_timers_top u_top (.*);

  always #6 clk_i = ~clk_i;

  // The predictor keeps its own copy of the configuration and of the block's state.
  logic [15:0] cal_q412;
  logic [31:0] routine_gap_ms;
  logic [31:0] anomaly_gap_ms;
  logic [15:0] adc_total;
  logic [3:0]  adc_count;
  logic [31:0] routine_stamp;
  logic [31:0] anomaly_stamp;

  // Readings still owed by the block, oldest first.
  reading_t    readings_due[$];
  int unsigned error_count = 0;
  int unsigned samples_sent = 0;
  int unsigned readings_seen = 0;
  int unsigned alert_hits[3] = '{0, 0, 0};
  int unsigned clamp_hits = 0;
  int unsigned sat_hits = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] clock_ms = '0;

  // Models one accepted sample. It returns 1 when the sample closes a block,
  // and in that case it also returns the reading that the block must produce.
  function automatic bit predict_reading(input logic [11:0] adc, input logic [11:0] temp,
                                         input logic [31:0] now, output reading_t rd);
    int          t16;
    logic [63:0] volts;
    logic [63:0] ec;
    logic [63:0] e2;
    logic [63:0] e3;
    longint      poly;
    logic [63:0] tds;
    logic [11:0] avg;
    rd = '0;
    adc_total = adc_total + 16'(adc);
    adc_count = adc_count + 4'd1;
    if (adc_count < 4'(BLOCK_LEN)) begin
      return 1'b0;
    end
    avg = 12'(adc_total / 16'(BLOCK_LEN));
    adc_total = '0;
    adc_count = '0;

    t16 = int'($signed(temp));
    rd.temp_clamped = (t16 < 0) || (t16 > int'(TEMP_MAX));
    if (t16 < 0) begin
      t16 = 0;
    end else if (t16 > int'(TEMP_MAX)) begin
      t16 = int'(TEMP_MAX);
    end

    volts = (64'(avg) * 64'(VOLT_SCALE)) / 64'(VOLT_DIV);
    ec = (volts * 64'(EC_GAIN) * 64'(cal_q412)) / (64'(int'(TEMP_OFFSET) + t16) * 64'd4096);
    if (ec > 64'(EC_MAX)) begin
      ec = 64'(EC_MAX);
    end
    e2 = (ec * ec) >> 16;
    e3 = (e2 * ec) >> 16;
    poly = longint'(64'(COEF_CUBE) * e3) - longint'(64'(COEF_SQUARE) * e2)
         + longint'(64'(COEF_LINEAR) * ec);
    if (poly < 0) begin
      poly = 0;
    end
    tds = 64'(poly) / 64'(TDS_DIV);
    rd.tds_saturated = tds > 64'(TDS_MAX);
    if (rd.tds_saturated) begin
      tds = 64'(TDS_MAX);
    end
    rd.tds_tenths = 17'(tds);
    rd.average_adc = avg;

    // Quality bands are 50, 100, 200, 300, 400 and 500 ppm, held here in tenths.
    if (tds <= 500) begin
      rd.quality_class = 3'd0;
    end else if (tds <= 1000) begin
      rd.quality_class = 3'd1;
    end else if (tds <= 2000) begin
      rd.quality_class = 3'd2;
    end else if (tds <= 3000) begin
      rd.quality_class = 3'd3;
    end else if (tds <= 4000) begin
      rd.quality_class = 3'd4;
    end else if (tds <= 5000) begin
      rd.quality_class = 3'd5;
    end else begin
      rd.quality_class = 3'd6;
    end

    // Both timers restart whenever either alert fires; the time difference wraps.
    rd.alert_kind = ALERT_NONE;
    if (tds > 64'(ANOMALY_LIMIT)) begin
      if (now - anomaly_stamp >= anomaly_gap_ms) begin
        rd.alert_kind = ALERT_ANOMALY;
      end
    end else if (now - routine_stamp >= routine_gap_ms) begin
      rd.alert_kind = ALERT_ROUTINE;
    end
    if (rd.alert_kind != ALERT_NONE) begin
      anomaly_stamp = now;
      routine_stamp = now;
    end
    return 1'b1;
  endfunction

  // Writes one register and mirrors the write in the predictor.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CAL:     cal_q412 = data[15:0];
      CFG_ROUTINE: routine_gap_ms = data;
      CFG_ANOMALY: anomaly_gap_ms = data;
      default: begin
      end
    endcase
  endtask

  // Sends one sample as a transaction.
  // This task is called only at a rising edge, and the caller owns in_valid_i after it returns.
  task automatic send_sample(input logic [11:0] adc, input logic [11:0] temp,
                             input logic [31:0] now, input bit typed, input reading_t want);
    reading_t rd;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    adc_sample_i <= adc;
    water_temp_i <= temp;
    now_ms_i <= now;
    // Ready is stable by the falling edge, so the next rising edge accepts the transaction.
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    samples_sent++;
    if (predict_reading(adc, temp, now, rd)) begin
      readings_due.push_back(typed ? want : rd);
    end
  endtask

  // Waits until every owed reading has arrived and the block has gone quiet.
  task automatic drain_block;
    in_valid_i <= 1'b0;
    while (readings_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // A block of samples around one level, sometimes pure noise, so that TDS covers every band.
  task automatic send_random_block;
    int          level;
    int          spread;
    int          v;
    logic [11:0] temp;
    level = $urandom_range(4095);
    spread = $urandom_range(3) == 0 ? 4095 : $urandom_range(60);
    for (int i = 0; i < BLOCK_LEN; i++) begin
      v = level + $urandom_range(2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      if ($urandom_range(4) == 0) begin
        temp = 12'($signed($urandom_range(2880)) - 880);
      end else begin
        temp = 12'($urandom_range(960));
      end
      case ($urandom_range(15))
        0: clock_ms = $urandom();
        1: clock_ms = clock_ms + $urandom_range(3000000);
        default: clock_ms = clock_ms + $urandom_range(120000);
      endcase
      send_sample(12'(v), temp, clock_ms, 1'b0, '0);
    end
  endtask

  // Receiver side: out_ready_i is redrawn every cycle at the current stall rate.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Output checker: the transaction is taken at the rising edge that follows this sample.
  always @(negedge clk_i) begin
    reading_t got;
    reading_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{tds_tenths_o, average_adc_o, quality_class_o, alert_e'(alert_kind_o),
              temp_clamped_o, tds_saturated_o};
      readings_seen++;
      if (readings_due.size() == 0) begin
        $display("%0t: reading with none owed: got %p", $time, got);
        error_count++;
      end else begin
        want = readings_due.pop_front();
        if (got !== want) begin
          $display("%0t: reading mismatch: expected %p, actual %p", $time, want, got);
          error_count++;
        end
        if (want.alert_kind <= ALERT_ROUTINE) alert_hits[want.alert_kind]++;
        clamp_hits += want.temp_clamped;
        sat_hits += want.tds_saturated;
      end
    end
  end

  // Watchdog: it counts cycles in which neither channel moves a transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
      $display("tds_meter_with_alert_timers_top_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sample_row_t script[NUM_DIRECTED];
    logic [31:0] phase_cfg[NUM_PHASES][3];

    // Predictor state after reset.
    cal_q412 = 16'd4096;
    routine_gap_ms = 32'd1260000;
    anomaly_gap_ms = 32'd600000;
    adc_total = '0;
    adc_count = '0;
    routine_stamp = '0;
    anomaly_stamp = '0;

    // First block: all-zero samples at the lowest temperature.
    // The temperature is clamped, TDS is zero, and the routine timer has run out just in time.
    for (int i = 0; i < BLOCK_LEN; i++) begin
      script[i] = '{12'd0, 12'($signed(-880)), 32'd1260000, 1'b0, '0};
    end
    script[BLOCK_LEN - 1].typed = 1'b1;
    script[BLOCK_LEN - 1].want = '{17'd0, 12'd0, 3'd0, ALERT_ROUTINE, 1'b1, 1'b0};
    // Second block: full-scale samples, ending at the hottest temperature.
    // The predictor gives the expected reading.
    for (int i = 0; i < BLOCK_LEN; i++) begin
      script[BLOCK_LEN + i] = '{12'd4095, 12'(i * 100), 32'hFFFF_FFFF, 1'b0, '0};
    end
    script[NUM_DIRECTED - 1].temp = 12'd2000;

    // Settings for the random phases: calibration, routine interval and anomaly interval.
    phase_cfg[0] = '{32'd4096, 32'd1260000, 32'd600000};
    phase_cfg[1] = '{32'd65535, 32'd0, 32'd0};
    phase_cfg[2] = '{32'd0, 32'd1, 32'd1};
    phase_cfg[3] = '{32'($urandom_range(65535)), 32'($urandom_range(1, 3000000)),
                     32'($urandom_range(1, 3000000))};
    phase_cfg[4] = '{32'd8192, 32'hFFFF_FFFF, 32'hFFFF_FFFF};

    // Reset is applied once, at the start of the run.
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      send_sample(script[i].adc, script[i].temp, script[i].now, script[i].typed,
                  script[i].want);
    end
    drain_block();

    // Each phase goes through one register setting and one idling pattern.
    // Every phase also writes the unused index, and the block must ignore that write.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 53; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 53; end
        default: begin sender_idle_pct = 22; receiver_stall_pct = 22; end
      endcase
      write_reg(CFG_CAL, phase_cfg[p][0]);
      write_reg(CFG_ROUTINE, phase_cfg[p][1]);
      write_reg(CFG_ANOMALY, phase_cfg[p][2]);
      write_reg(CFG_UNUSED, $urandom());
      for (int b = 0; b < BLOCKS_PER_PHASE; b++) begin
        send_random_block();
      end
      drain_block();
    end

    $display("Sent %0d samples and checked %0d readings over %0d register settings.",
             samples_sent, readings_seen, NUM_PHASES);
    $display("Alerts none/anomaly/routine %0d/%0d/%0d, clamped %0d, saturated %0d.",
             alert_hits[0], alert_hits[1], alert_hits[2], clamp_hits, sat_hits);
    if (error_count == 0) begin
      $display("tds_meter_with_alert_timers_top_tb passed");
    end else begin
      $display("tds_meter_with_alert_timers_top_tb failed");
    end
    $finish;
  end

endmodule
